### design/pfma_pkg.sv
// Shared types, constants and helper functions for the page frame map allocator.
// Used by every module of the block; no dependencies of its own.
package pfma_pkg;

    // Default sizes of the map
    localparam int DEF_NUM_PAGES      = 65536;
    localparam int DEF_RESERVED_PAGES = 2560;
    localparam int QUEUE_DEPTH        = 4;

    // Fixed field widths
    localparam int WORD_W     = 64;   // map bits held in one memory word
    localparam int BIT_W      = 6;    // bit index within a word
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 20;   // page number taken from a byte address
    localparam int LIM_W      = 21;   // page counts up to the largest map size
    localparam int MEMKB_W    = 22;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int TDATA_W    = 40;
    localparam int EXTRA_KB   = 1024;

    // Commands on the request channel
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd2;

    // Classified operations handed from front to back
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_REPLY = 2'd3;   // answer at once with the given status

    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] page;
        logic [STAT_W-1:0] status;
    } req_t;

    // Index of the lowest set bit (0 when none is set)
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Bits j of a word for which base + j < bound
    function automatic logic [WORD_W-1:0] span_mask(input logic [LIM_W-1:0] base,
                                                    input logic [LIM_W-1:0] bound);
        logic [LIM_W-1:0]  diff;
        logic [WORD_W-1:0] m;
        diff = bound - base;
        if (bound <= base) begin
            m = '0;
        end else if (diff >= LIM_W'(WORD_W)) begin
            m = '1;
        end else begin
            m = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
        end
        return m;
    endfunction

endpackage

### design/page_frame_map_allocator.sv
// Page frame map allocator: one used/free bit per 4 KiB page, first-fit allocation.
// Top level; instantiates pfma_front, pfma_queue and pfma_back, uses pfma_pkg.
//
// Usage:
//   s_ channel carries requests: command (0 init, 1 allocate, 2 free) and a byte
//   address for free. m_ channel returns one result per request: the allocated
//   byte address and a status (0 ok, 1 no free page, 2 free ignored).
//   cfg_ channel writes memory_kb, which sets the free page limit used by init;
//   write it only while no request is outstanding.
//   Operation, with W = NUM_PAGES/64 map words (1024 by default):
//     free        reads the map word that holds the page, then clears its bit
//     init        rewrites all W map words, one map word per cycle
//     allocate    scans words from the lowest word that may
//                 hold a free page; one word read per cycle from the map memory
//   The map memory has a single port per direction; init and allocate sweep it.
//   Requests are decoded and queued (4 deep) while the back end works, so the
//   input keeps flowing until the queue fills.
//   Reset: a pass over all W words marks every page used; s_tready stays low
//   meanwhile. A stalled m_tready holds the result register; the back end then
//   waits with the next result and the queue absorbs further requests.
module page_frame_map_allocator
    import pfma_pkg::*;
#(
    parameter int NUM_PAGES      = DEF_NUM_PAGES,
    parameter int RESERVED_PAGES = DEF_RESERVED_PAGES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,     // [1:0] command, [33:2] page_byte_address
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,     // [31:0] allocated_address, [33:32] status
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MEMKB_W-1:0] cfg_data     // memory_kb
);

    logic [MEMKB_W-1:0] memory_kb_reg, memory_kb_next;
    logic               clear_busy;
    logic               push_valid, push_ready;
    logic               pop_valid, pop_ready;
    req_t               push_req, pop_req;

    // Configuration register
    assign cfg_ready      = 1'b1;
    assign memory_kb_next = (cfg_valid && cfg_ready) ? cfg_data : memory_kb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_kb_reg <= '0;
        end else begin
            memory_kb_reg <= memory_kb_next;
        end
    end

    pfma_front #(
        .NUM_PAGES (NUM_PAGES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    pfma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    pfma_back #(
        .NUM_PAGES      (NUM_PAGES),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .memory_kb  (memory_kb_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### design/pfma_front.sv
// Front end: takes requests from the input channel, decodes and checks them.
// Depends on pfma_pkg; feeds pfma_queue.
module pfma_front
    import pfma_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,     // [1:0] command, [33:2] page_byte_address
    input  logic               clear_busy,
    output logic               push_valid,
    input  logic               push_ready,
    output req_t               push_req
);

    logic             valid_reg, valid_next;
    req_t             req_reg, req_next;
    req_t             decoded;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [PAGE_W-1:0] page;

    assign cmd  = s_tdata[CMD_W-1:0];
    assign addr = s_tdata[CMD_W+ADDR_W-1:CMD_W];
    assign page = addr[ADDR_W-1:PAGE_SHIFT];

    // Decode the command; bad frees are answered without touching the map
    always_comb begin
        decoded.op     = OP_REPLY;
        decoded.page   = page;
        decoded.status = ST_OK;
        case (cmd)
            CMD_INIT:  decoded.op = OP_INIT;
            CMD_ALLOC: decoded.op = OP_ALLOC;
            CMD_FREE: begin
                if (addr == '0 || {1'b0, page} >= LIM_W'(NUM_PAGES)) begin
                    decoded.status = ST_IGNORED;
                end else begin
                    decoded.op = OP_FREE;
                end
            end
            default: decoded.op = OP_REPLY;
        endcase
    end

    // One holding stage towards the queue
    assign s_tready   = !clear_busy && (!valid_reg || push_ready);
    assign push_valid = valid_reg;
    assign push_req   = req_reg;

    always_comb begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (push_ready) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            req_next   = decoded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        req_reg <= req_next;
    end

endmodule

### design/pfma_queue.sv
// Short FIFO of decoded requests between front and back end.
// Depends on pfma_pkg for the request type.
module pfma_queue
    import pfma_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  req_t push_req,
    output logic pop_valid,
    input  logic pop_ready,
    output req_t pop_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

### design/pfma_back.sv
// Back end: page map memory, sweep/scan sequencer and result register.
// Depends on pfma_pkg; takes decoded requests from pfma_queue.
module pfma_back
    import pfma_pkg::*;
#(
    parameter int NUM_PAGES      = DEF_NUM_PAGES,
    parameter int RESERVED_PAGES = DEF_RESERVED_PAGES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [MEMKB_W-1:0] memory_kb,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  req_t               pop_req,
    output logic               clear_busy,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata     // [31:0] allocated_address, [33:32] status
);

    localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int HINT_W    = WIDX_W + 1;
    localparam int RESV_SAT  = (RESERVED_PAGES > NUM_PAGES) ? NUM_PAGES : RESERVED_PAGES;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_INIT    = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_FREE_RD = 3'd4;
    localparam logic [2:0] S_FREE_WR = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // Map memory: one bit per page, set means used
    logic [WORD_W-1:0] map_mem [NUM_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en, wr_en;
    logic [WIDX_W-1:0] rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [2:0]         state_reg, state_next;
    logic [HINT_W-1:0]  ptr_reg, ptr_next;       // sweep / scan issue pointer
    logic [HINT_W-1:0]  hint_reg, hint_next;     // no free page below this word
    logic [WIDX_W-1:0]  chk_ptr_reg, chk_ptr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [LIM_W-1:0]   limit_reg, limit_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [MEMKB_W:0]   kb_sum;
    logic [LIM_W-1:0]   limit_raw;
    logic [LIM_W-1:0]   sweep_base;
    logic               issue;
    logic [BIT_W-1:0]   free_bit;
    logic [WIDX_W-1:0]  free_word;

    // Free page limit: (memory_kb + 1024) / 4, capped at the map size
    assign kb_sum    = {1'b0, memory_kb} + (MEMKB_W + 1)'(EXTRA_KB);
    assign limit_raw = kb_sum[MEMKB_W:2];

    assign sweep_base = LIM_W'({ptr_reg[WIDX_W-1:0], {BIT_W{1'b0}}});
    assign issue      = (ptr_reg < HINT_W'(NUM_WORDS));
    assign free_bit   = lowest_set(~rd_data_reg);
    assign free_word  = page_reg[WIDX_W+BIT_W-1:BIT_W];

    assign clear_busy = (state_reg == S_CLEAR);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        hint_next       = hint_reg;
        chk_ptr_next    = chk_ptr_reg;
        chk_valid_next  = chk_valid_reg;
        limit_next      = limit_reg;
        page_next       = page_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        pop_ready       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[WIDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[WIDX_W-1:0];
        wr_data         = '1;

        case (state_reg)
            // Post-reset pass: every page used
            S_CLEAR: begin
                wr_en = 1'b1;
                if (ptr_reg == HINT_W'(NUM_WORDS - 1)) begin
                    ptr_next   = '0;
                    hint_next  = HINT_W'(NUM_WORDS);
                    state_next = S_IDLE;
                end else begin
                    ptr_next = ptr_reg + HINT_W'(1);
                end
            end

            S_IDLE: begin
                if (pop_valid) begin
                    pop_ready       = 1'b1;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    case (pop_req.op)
                        OP_INIT: begin
                            limit_next = (limit_raw > LIM_W'(NUM_PAGES)) ?
                                         LIM_W'(NUM_PAGES) : limit_raw;
                            ptr_next   = '0;
                            state_next = S_INIT;
                        end
                        OP_ALLOC: begin
                            if (hint_reg == HINT_W'(NUM_WORDS)) begin
                                res_status_next = ST_NONE_FREE;
                                state_next      = S_DONE;
                            end else begin
                                ptr_next       = hint_reg;
                                chk_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            page_next  = pop_req.page;
                            state_next = S_FREE_RD;
                        end
                        default: begin
                            res_status_next = pop_req.status;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            // Rewrite the map: free below the limit, reserved pages used
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = ~span_mask(sweep_base, limit_reg)
                        | span_mask(sweep_base, LIM_W'(RESV_SAT));
                if (ptr_reg == HINT_W'(NUM_WORDS - 1)) begin
                    hint_next  = '0;
                    state_next = S_DONE;
                end else begin
                    ptr_next = ptr_reg + HINT_W'(1);
                end
            end

            // First-fit scan: one word read per cycle, checked in the next cycle
            S_SCAN: begin
                rd_en          = issue;
                chk_valid_next = issue;
                chk_ptr_next   = ptr_reg[WIDX_W-1:0];
                if (issue) begin
                    ptr_next = ptr_reg + HINT_W'(1);
                end
                if (chk_valid_reg) begin
                    if (!(&rd_data_reg)) begin
                        wr_en         = 1'b1;
                        wr_addr       = chk_ptr_reg;
                        wr_data       = rd_data_reg | (WORD_W'(1) << free_bit);
                        hint_next     = HINT_W'(chk_ptr_reg);
                        res_addr_next = ADDR_W'({chk_ptr_reg, free_bit}) << PAGE_SHIFT;
                        state_next    = S_DONE;
                    end else if (chk_ptr_reg == WIDX_W'(NUM_WORDS - 1)) begin
                        hint_next       = HINT_W'(NUM_WORDS);
                        res_status_next = ST_NONE_FREE;
                        state_next      = S_DONE;
                    end
                end
            end

            S_FREE_RD: begin
                rd_en      = 1'b1;
                rd_addr    = free_word;
                state_next = S_FREE_WR;
            end

            S_FREE_WR: begin
                wr_en   = 1'b1;
                wr_addr = free_word;
                wr_data = rd_data_reg & ~(WORD_W'(1) << page_reg[BIT_W-1:0]);
                if (HINT_W'(free_word) < hint_reg) begin
                    hint_next = HINT_W'(free_word);
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'({res_status_reg, res_addr_reg});
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            hint_reg      <= HINT_W'(NUM_WORDS);
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            hint_reg      <= hint_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        chk_ptr_reg    <= chk_ptr_next;
        limit_reg      <= limit_next;
        page_reg       <= page_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Map memory ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Checks
    a_hint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg <= HINT_W'(NUM_WORDS))
        else $error("search hint beyond map");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("map written outside an operation");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion state");

    a_none_free_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg != ST_OK) |-> res_addr_reg == '0)
        else $error("failed request carries an address");

endmodule

### sim/tb_page_frame_map_allocator.sv
// Self-checking testbench for page_frame_map_allocator: a table of directed probes, then
// random request streams, each result checked against a page map model or a probe's reply.
// Depends on pfma_pkg and the page_frame_map_allocator RTL.
`timescale 1ns / 1ps

module tb_page_frame_map_allocator;
    import pfma_pkg::*;

    localparam int MAP_PAGES   = DEF_NUM_PAGES;
    localparam int RESV_PAGES  = DEF_RESERVED_PAGES;
    localparam int STALL_LIMIT = 20000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES = 1100;    // a full map sweep plus margin
    localparam int HOLD_OFF    = 1600;    // outlasts an init sweep, so results back up
    localparam int PHASE_ITEMS = 100;
    localparam logic [CMD_W-1:0]   CMD_SPARE    = 2'd3;   // unused command code
    localparam logic [MEMKB_W-1:0] KB_MAX_RANGE = 22'd4193280;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
    } frame_reply_t;

    typedef struct {
        bit                 is_cfg;
        logic [MEMKB_W-1:0] kb;
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  addr;
        bit                 typed;
        frame_reply_t       reply;
    } probe_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [MEMKB_W-1:0] cfg_data  = '0;

    // Model of the page map
    bit                 page_used_map [MAP_PAGES];
    int unsigned        scan_floor;        // every page below this one is in use
    logic [MEMKB_W-1:0] model_memory_kb;

    frame_reply_t replies_due[$];
    int unsigned  held_frames[$];          // pages handed out and not yet freed
    probe_t       opening_probes[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;

    // Knobs shared with the stream processes
    bit source_jitter = 1'b0;
    bit sink_jitter   = 1'b0;
    bit sink_hold_req = 1'b0;

    always #2 aclk = ~aclk;

    page_frame_map_allocator #(
        .NUM_PAGES      (MAP_PAGES),
        .RESERVED_PAGES (RESV_PAGES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 3);
    endfunction

    // Apply one request to the model map and work out its result
    function automatic frame_reply_t model_request(input logic [CMD_W-1:0]  cmd,
                                                   input logic [ADDR_W-1:0] addr);
        frame_reply_t r;
        int unsigned  limit;
        int unsigned  resv;
        int unsigned  page;
        r.addr   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INIT: begin
                limit = model_memory_kb;
                limit = (limit + EXTRA_KB) / 4;
                if (limit > MAP_PAGES) begin
                    limit = MAP_PAGES;
                end
                resv = (RESV_PAGES > MAP_PAGES) ? MAP_PAGES : RESV_PAGES;
                for (int unsigned i = 0; i < MAP_PAGES; i++) begin
                    page_used_map[i] = (i < resv) || (i >= limit);
                end
                scan_floor = resv;
            end
            CMD_ALLOC: begin
                page = scan_floor;
                while (page < MAP_PAGES && page_used_map[page]) begin
                    page++;
                end
                if (page < MAP_PAGES) begin
                    page_used_map[page] = 1'b1;
                    r.addr     = ADDR_W'(page) << PAGE_SHIFT;
                    scan_floor = page + 1;
                end else begin
                    r.status   = ST_NONE_FREE;
                    scan_floor = MAP_PAGES;
                end
            end
            CMD_FREE: begin
                page = addr >> PAGE_SHIFT;
                if (addr == '0 || page >= MAP_PAGES) begin
                    r.status = ST_IGNORED;
                end else begin
                    page_used_map[page] = 1'b0;
                    if (page < scan_floor) begin
                        scan_floor = page;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one request, wait for acceptance, record what must come back
    task automatic issue_request(input logic [CMD_W-1:0]  cmd,
                                 input logic [ADDR_W-1:0] addr,
                                 input bit                typed,
                                 input frame_reply_t      typed_reply);
        frame_reply_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({addr, cmd});
        do @(posedge aclk); while (!s_tready);
        r = model_request(cmd, addr);
        replies_due.push_back(typed ? typed_reply : r);
        if (cmd == CMD_INIT) begin
            held_frames.delete();
        end else if (cmd == CMD_ALLOC && r.status == ST_OK) begin
            held_frames.push_back(r.addr >> PAGE_SHIFT);
        end
        if (source_jitter && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (idle_gap()) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every outstanding request has been answered
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_memory_kb(input logic [MEMKB_W-1:0] kb);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= kb;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid       <= 1'b0;
        model_memory_kb = kb;
    endtask

    // Mostly allocate/free traffic on pages really held, with some noise
    task automatic issue_random_request();
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  cmd;
        int                pick;
        int                slot;
        addr = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            cmd = CMD_INIT;
        end else if (pick < 5) begin
            cmd = CMD_SPARE;
        end else if (pick < 50) begin
            cmd = CMD_ALLOC;
        end else begin
            cmd = CMD_FREE;
            if (pick < 75 && held_frames.size() != 0) begin
                slot = $urandom_range(0, held_frames.size() - 1);
                addr = (ADDR_W'(held_frames[slot]) << PAGE_SHIFT) | (addr & 32'h0000_0FFF);
                held_frames.delete(slot);
            end else if (pick < 85) begin
                addr = {4'h0, addr[27:0]};                    // page inside the map
            end else if (pick < 90) begin
                addr = ADDR_W'($urandom_range(1, 4095));      // inside page zero
            end else if (pick < 93) begin
                addr = '0;
            end
            // otherwise any address, mostly beyond the map
        end
        issue_request(cmd, addr, 1'b0, '0);
    endtask

    task automatic add_probe(input bit is_cfg, input logic [MEMKB_W-1:0] kb,
                             input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input bit typed, input logic [ADDR_W-1:0] want_addr,
                             input logic [STAT_W-1:0] want_status);
        probe_t p;
        p.is_cfg       = is_cfg;
        p.kb           = kb;
        p.cmd          = cmd;
        p.addr         = addr;
        p.typed        = typed;
        p.reply.addr   = want_addr;
        p.reply.status = want_status;
        opening_probes.push_back(p);
    endtask

    // Result checker
    always @(posedge aclk) begin : result_check
        frame_reply_t seen;
        frame_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.addr   = m_tdata[ADDR_W-1:0];
            seen.status = m_tdata[ADDR_W +: STAT_W];
            if (replies_due.size() == 0) begin
                $error("result with no request outstanding: allocated_address=%h status=%0d",
                       seen.addr, seen.status);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (seen.addr !== want.addr) begin
                    $error("allocated_address: expected %h, got %h", want.addr, seen.addr);
                    mismatch_count++;
                end
                if (seen.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, seen.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        stall = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall         = HOLD_OFF;
            end else if (stall == 0 && sink_jitter && $urandom_range(0, 3) == 0) begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        probe_t             p;
        logic [MEMKB_W-1:0] kb;
        for (int i = 0; i < MAP_PAGES; i++) begin
            page_used_map[i] = 1'b1;
        end
        scan_floor      = MAP_PAGES;
        model_memory_kb = '0;

        // Directed probes; after reset every page is marked used
        add_probe(0, '0, CMD_ALLOC, 32'hFFFF_FFFF, 1, 32'h0, ST_NONE_FREE);
        add_probe(0, '0, CMD_FREE,  32'h0000_0000, 1, 32'h0, ST_IGNORED);
        add_probe(0, '0, CMD_FREE,  32'h1000_0000, 1, 32'h0, ST_IGNORED);  // first page off the map
        add_probe(0, '0, CMD_FREE,  32'hFFFF_FFFF, 1, 32'h0, ST_IGNORED);
        add_probe(0, '0, CMD_SPARE, 32'hFFFF_FFFF, 1, 32'h0, ST_OK);
        add_probe(0, '0, CMD_FREE,  32'h0000_0FFF, 1, 32'h0, ST_OK);       // frees page zero
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h0, ST_OK);       // page zero handed out
        add_probe(0, '0, CMD_FREE,  32'h0000_0001, 1, 32'h0, ST_OK);
        add_probe(0, '0, CMD_FREE,  32'h0000_0001, 1, 32'h0, ST_OK);       // already free
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h0, ST_OK);
        add_probe(0, '0, CMD_INIT,  32'hFFFF_FFFF, 1, 32'h0, ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h0, ST_NONE_FREE); // limit under reserve
        // Largest memory: free limit saturates at the map size
        add_probe(1, KB_MAX_RANGE, CMD_INIT, '0, 0, '0, ST_OK);
        add_probe(0, '0, CMD_INIT,  32'h0,         1, 32'h0,         ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h00A0_0000, ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h00A0_1000, ST_OK);
        add_probe(0, '0, CMD_FREE,  32'h00A0_0ABC, 1, 32'h0,         ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h00A0_0000, ST_OK);
        add_probe(0, '0, CMD_FREE,  32'h0FFF_FFFF, 1, 32'h0,         ST_OK); // last page
        add_probe(0, '0, CMD_ALLOC, 32'h5555_5555, 0, '0, ST_OK);
        // Two pages above the reserve, then exhaustion
        add_probe(1, 22'd9224, CMD_INIT, '0, 0, '0, ST_OK);
        add_probe(0, '0, CMD_INIT,  32'h0,         1, 32'h0,         ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h00A0_0000, ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0,         1, 32'h00A0_1000, ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'hAAAA_AAAA, 1, 32'h0,         ST_NONE_FREE);
        add_probe(0, '0, CMD_FREE,  32'h00A0_1000, 0, '0, ST_OK);
        add_probe(1, 22'h3F_FFFF, CMD_INIT, '0, 0, '0, ST_OK);
        add_probe(0, '0, CMD_INIT,  32'h0, 0, '0, ST_OK);
        add_probe(0, '0, CMD_ALLOC, 32'h0, 0, '0, ST_OK);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        source_jitter = 1'b1;
        sink_jitter   = 1'b1;
        foreach (opening_probes[i]) begin
            p = opening_probes[i];
            if (p.is_cfg) begin
                set_memory_kb(p.kb);
            end else begin
                issue_request(p.cmd, p.addr, p.typed, p.reply);
            end
        end

        // Random phases, each under its own memory size
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       kb = '0;
                1:       kb = KB_MAX_RANGE;
                2:       kb = 22'd9312;      // 24 pages above the reserve
                3:       kb = 22'h3F_FFFF;
                4:       kb = 22'd10240;     // 256 pages above the reserve
                default: kb = MEMKB_W'($urandom_range(0, 22'h3F_FFFF));
            endcase
            set_memory_kb(kb);
            source_jitter = (ph % 3) != 2;
            sink_jitter   = (ph % 4) != 3;
            issue_request(CMD_INIT, $urandom, 1'b0, '0);
            if (ph == 1) begin
                // long hold-off on the result side while requests keep coming
                sink_hold_req = 1'b1;
                source_jitter = 1'b0;
                repeat (16) issue_random_request();
                source_jitter = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue_random_request();
                if ($urandom_range(0, 49) == 0) begin
                    drain_replies();
                end
            end
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
